/* hw/rtl/lfsa_pkg.sv */
`timescale 1ns / 1ps
package lfsa_pkg;

   localparam int CoefW    = 32;
   localparam int FracW    = 50;
   localparam int DistW    = 32;
   localparam int SqW      = 64;
   localparam int LabelW   = 31;
   localparam int CsrAddrW = 6;
   localparam int CsrDataW = 64;

   typedef enum logic [2:0] {
      CSR_M00_M01 = 3'd0,
      CSR_M02_M10 = 3'd1,
      CSR_M11_M12 = 3'd2,
      CSR_M20_M21 = 3'd3,
      CSR_M22     = 3'd4,
      CSR_TOL_SQ  = 3'd5,
      CSR_LABEL   = 3'd6
   } csr_index_type;

   localparam logic [31:0] LABEL_NONE = 32'hFFFF_FFFF;

   // fields that ride along the pipe untouched until the last stage
   typedef struct packed {
      logic [31:0] prior_error;
      logic [31:0] prior_label;
      logic        last_vector;
   } side_type;

endpackage

/* hw/rtl/lfsa_req_if.sv */
`timescale 1ns / 1ps
interface lfsa_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] g_x;
   logic signed [31:0] g_y;
   logic signed [31:0] g_z;
   logic        [31:0] prior_error;
   logic signed [31:0] prior_label;
   logic               last_vector;

   modport source (output valid, g_x, g_y, g_z, prior_error, prior_label, last_vector,
                   input ready);
   modport sink   (input valid, g_x, g_y, g_z, prior_error, prior_label, last_vector,
                   output ready);
endinterface

/* hw/rtl/lfsa_rsp_if.sv */
`timescale 1ns / 1ps
interface lfsa_rsp_if;
   logic               valid;
   logic               ready;
   logic        [31:0] new_error;
   logic signed [31:0] new_label;
   logic               assigned;
   logic               last_result;

   modport source (output valid, new_error, new_label, assigned, last_result,
                   input ready);
   modport sink   (input valid, new_error, new_label, assigned, last_result,
                   output ready);
endinterface

/* hw/rtl/lattice_fit_score_assign.sv */
// Scores scattering vectors against a programmed 3x3 orientation matrix and
// assigns the grain label to vectors that fit; misses that held it get LABEL_NONE.
// Channels: req carries one vector beat (g_x/g_y/g_z, prior error and label,
// last flag); rsp returns one beat per request, in order, with the updated
// error and label, the assigned flag and the copied last flag.
// Program the matrix, tolerance and label over the APB port (8-byte register
// spacing, pready always high) while no beats are in flight.
// A beat passes through five register stages: products, row sums, distance,
// squares, score/select. Throughput: one beat per cycle while rsp is not
// stalled; each stage holds a dot-product term, a sum, a subtract or a 32x32
// multiply, so every stage can take a new beat each cycle.
// A stall on rsp backs up stage by stage; a stage holding a beat only moves
// when the stage after it has room, so nothing is dropped or repeated, and
// empty stages still fill while the output is stalled.
// Reset (synchronous) clears the configuration registers to zero and empties the pipe.
`timescale 1ns / 1ps
module lattice_fit_score_assign (
   input  logic                             clock,
   input  logic                             reset,
   lfsa_req_if.sink                         req,
   lfsa_rsp_if.source                       rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lfsa_pkg::CsrAddrW-1:0]    paddr,
   input  logic [lfsa_pkg::CsrDataW-1:0]    pwdata,
   output logic [lfsa_pkg::CsrDataW-1:0]    prdata,
   output logic                             pready
);

   // ---------------- configuration registers ----------------
   logic [63:0]                     m00_m01_ff, m02_m10_ff, m11_m12_ff, m20_m21_ff;
   logic [31:0]                     m22_ff;
   logic [31:0]                     tol_sq_ff;
   logic [lfsa_pkg::LabelW-1:0]     label_ff;
   lfsa_pkg::csr_index_type         csr_index;
   logic                            csr_write;

   assign pready    = 1'b1;
   assign csr_index = lfsa_pkg::csr_index_type'(paddr[5:3]);
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         m00_m01_ff <= '0;
         m02_m10_ff <= '0;
         m11_m12_ff <= '0;
         m20_m21_ff <= '0;
         m22_ff     <= '0;
         tol_sq_ff  <= '0;
         label_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lfsa_pkg::CSR_M00_M01: m00_m01_ff <= pwdata;
            lfsa_pkg::CSR_M02_M10: m02_m10_ff <= pwdata;
            lfsa_pkg::CSR_M11_M12: m11_m12_ff <= pwdata;
            lfsa_pkg::CSR_M20_M21: m20_m21_ff <= pwdata;
            lfsa_pkg::CSR_M22:     m22_ff     <= pwdata[31:0];
            lfsa_pkg::CSR_TOL_SQ:  tol_sq_ff  <= pwdata[31:0];
            lfsa_pkg::CSR_LABEL:   label_ff   <= pwdata[lfsa_pkg::LabelW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lfsa_pkg::CSR_M00_M01: prdata = m00_m01_ff;
         lfsa_pkg::CSR_M02_M10: prdata = m02_m10_ff;
         lfsa_pkg::CSR_M11_M12: prdata = m11_m12_ff;
         lfsa_pkg::CSR_M20_M21: prdata = m20_m21_ff;
         lfsa_pkg::CSR_M22:     prdata = {32'd0, m22_ff};
         lfsa_pkg::CSR_TOL_SQ:  prdata = {32'd0, tol_sq_ff};
         lfsa_pkg::CSR_LABEL:   prdata = {33'd0, label_ff};
         default:               prdata = '0;
      endcase
   end

   // row-major coefficients
   logic signed [lfsa_pkg::CoefW-1:0] coef [9];
   logic signed [lfsa_pkg::CoefW-1:0] gvec [3];

   assign coef[0] = m00_m01_ff[63:32];
   assign coef[1] = m00_m01_ff[31:0];
   assign coef[2] = m02_m10_ff[63:32];
   assign coef[3] = m02_m10_ff[31:0];
   assign coef[4] = m11_m12_ff[63:32];
   assign coef[5] = m11_m12_ff[31:0];
   assign coef[6] = m20_m21_ff[63:32];
   assign coef[7] = m20_m21_ff[31:0];
   assign coef[8] = m22_ff;

   assign gvec[0] = req.g_x;
   assign gvec[1] = req.g_y;
   assign gvec[2] = req.g_z;

   // ---------------- stage control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5;

   // a stage advances when it is empty or the next one advances
   assign en5 = ~rsp_valid_ff | rsp.ready;
   assign en4 = ~v4_ff | en5;
   assign en3 = ~v3_ff | en4;
   assign en2 = ~v2_ff | en3;
   assign en1 = ~v1_ff | en2;

   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= req.valid;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) v4_ff        <= v3_ff;
         if (en5) rsp_valid_ff <= v4_ff;
      end
   end

   lfsa_pkg::side_type side_in;
   lfsa_pkg::side_type side1_ff, side2_ff, side3_ff, side4_ff;

   assign side_in.prior_error = req.prior_error;
   assign side_in.prior_label = req.prior_label;
   assign side_in.last_vector = req.last_vector;

   // ---------------- stage 1: nine products, fraction bits only ----------------
   logic [lfsa_pkg::FracW-1:0] prod_ff [9];
   logic signed [63:0]         prod_full [9];

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         assign prod_full[r*3+c] = coef[r*3+c] * gvec[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_full[i][lfsa_pkg::FracW-1:0];
         end
         side1_ff <= side_in;
      end
   end

   // ---------------- stage 2: row sums modulo the integer part ----------------
   logic [lfsa_pkg::FracW-1:0] frac_ff [3];

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int r = 0; r < 3; r++) begin
            frac_ff[r] <= prod_ff[r*3] + prod_ff[r*3+1] + prod_ff[r*3+2];
         end
         side2_ff <= side1_ff;
      end
   end

   // ---------------- stage 3: distance to nearest integer ----------------
   localparam logic [lfsa_pkg::FracW-1:0] HalfFrac =
      lfsa_pkg::FracW'(1) << (lfsa_pkg::FracW - 1);

   logic [lfsa_pkg::DistW-1:0] dist_ff [3];
   logic [lfsa_pkg::FracW-1:0] dist_full [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         // 1 - f wraps cleanly in FracW bits since f is nonzero here
         dist_full[r] = (frac_ff[r] <= HalfFrac) ? frac_ff[r] : (~frac_ff[r] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int r = 0; r < 3; r++) begin
            dist_ff[r] <= dist_full[r][lfsa_pkg::FracW-1 -: lfsa_pkg::DistW];
         end
         side3_ff <= side2_ff;
      end
   end

   // ---------------- stage 4: squares ----------------
   logic [lfsa_pkg::SqW-1:0] sq_ff [3];

   always_ff @(posedge clock) begin
      if (en4) begin
         for (int r = 0; r < 3; r++) begin
            sq_ff[r] <= lfsa_pkg::SqW'(dist_ff[r]) * lfsa_pkg::SqW'(dist_ff[r]);
         end
         side4_ff <= side3_ff;
      end
   end

   // ---------------- stage 5: score, compare, select ----------------
   logic [lfsa_pkg::SqW:0] sum_round;
   logic [31:0]            score;
   logic                   hit;
   logic [31:0]            label_ext;
   logic [31:0]            new_error_in, new_label_in;
   logic [31:0]            new_error_ff, new_label_ff;
   logic                   assigned_ff, last_result_ff;

   // the sum is at most 0.75, so the rounded score never needs saturation
   assign sum_round = (lfsa_pkg::SqW+1)'(sq_ff[0]) + (lfsa_pkg::SqW+1)'(sq_ff[1])
                    + (lfsa_pkg::SqW+1)'(sq_ff[2]) + ((lfsa_pkg::SqW+1)'(1) << 33);
   assign score     = {1'b0, sum_round[64:34]};
   assign label_ext = {1'b0, label_ff};
   assign hit       = (score < tol_sq_ff) && (score < side4_ff.prior_error);

   always_comb begin
      if (hit) begin
         new_error_in = score;
         new_label_in = label_ext;
      end else begin
         new_error_in = side4_ff.prior_error;
         new_label_in = (side4_ff.prior_label == label_ext) ? lfsa_pkg::LABEL_NONE
                                                            : side4_ff.prior_label;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         new_error_ff   <= new_error_in;
         new_label_ff   <= new_label_in;
         assigned_ff    <= hit;
         last_result_ff <= side4_ff.last_vector;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.new_error   = new_error_ff;
   assign rsp.new_label   = new_label_ff;
   assign rsp.assigned    = assigned_ff;
   assign rsp.last_result = last_result_ff;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

   localparam int          PIPE_DEPTH    = 5;
   localparam int          HOLD_CYCLES   = 80;
   localparam int          SQUEEZE_BEATS = 40;
   localparam int          RANDOM_PHASES = 6;
   localparam int          PHASE_BEATS   = 255;
   localparam int          REG_STRIDE    = 8;
   localparam int          UNUSED_INDEX  = 7;
   localparam int          MAX_PRINTED   = 100;
   localparam int          RUN_LIMIT_NS  = 10_000_000;
   localparam logic [31:0] G_ONE         = 32'h1000_0000;  // 1.0 in Q4.28
   localparam logic [31:0] G_HALF        = 32'h0800_0000;  // 0.5 in Q4.28
   localparam int          M_ONE         = 1 << 22;        // 1.0 in Q10.22
   localparam logic [50:0] HALF_FRAC     = 51'd1 << 49;
   localparam logic [50:0] FULL_FRAC     = 51'd1 << 50;
   localparam int          EXTREME_COEF [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 0, M_ONE};
   localparam int          EXTREME_G [4]    = '{32'h7FFF_FFFF, 32'h8000_0000, 0, -1};

   typedef struct packed {
      logic signed [31:0] g_x;
      logic signed [31:0] g_y;
      logic signed [31:0] g_z;
      logic        [31:0] prior_error;
      logic signed [31:0] prior_label;
      logic               last_vector;
   } vector_beat_type;

   typedef struct packed {
      logic        [31:0] new_error;
      logic signed [31:0] new_label;
      logic               assigned;
      logic               last_result;
   } fit_result_type;

   class fit_scoreboard;
      int             coef [3][3];
      logic [31:0]    tol_sq;
      logic [31:0]    grain_label;
      fit_result_type expected_fits [$];
      int             mismatches;

      function new();
         foreach (coef[r, c]) coef[r][c] = 0;
         tol_sq      = '0;
         grain_label = '0;
         mismatches  = 0;
      endfunction

      function void set_reg(int idx, logic [63:0] value);
         case (idx)
            lfsa_pkg::CSR_M00_M01: begin
               coef[0][0] = value[63:32];
               coef[0][1] = value[31:0];
            end
            lfsa_pkg::CSR_M02_M10: begin
               coef[0][2] = value[63:32];
               coef[1][0] = value[31:0];
            end
            lfsa_pkg::CSR_M11_M12: begin
               coef[1][1] = value[63:32];
               coef[1][2] = value[31:0];
            end
            lfsa_pkg::CSR_M20_M21: begin
               coef[2][0] = value[63:32];
               coef[2][1] = value[31:0];
            end
            lfsa_pkg::CSR_M22:    coef[2][2] = value[31:0];
            lfsa_pkg::CSR_TOL_SQ: tol_sq = value[31:0];
            lfsa_pkg::CSR_LABEL:  grain_label = {1'b0, value[30:0]};
            default: ;
         endcase
      endfunction

      // squared misfit of M*g to the nearest lattice point, Q2.30
      function logic [31:0] fit_score(int gx, int gy, int gz);
         longint unsigned h;
         logic [50:0]     frac;
         logic [50:0]     gap;
         logic [31:0]     d32;
         logic [65:0]     total;
         total = '0;
         for (int r = 0; r < 3; r++) begin
            h = longint'(coef[r][0]) * longint'(gx) + longint'(coef[r][1]) * longint'(gy)
              + longint'(coef[r][2]) * longint'(gz);
            frac = {1'b0, h[49:0]};
            gap = (frac <= HALF_FRAC) ? frac : FULL_FRAC - frac;
            d32 = gap[49:18];
            total += {34'b0, d32} * {34'b0, d32};
         end
         total += 66'd1 << 33;
         return total[65:34];
      endfunction

      function void note_vector(vector_beat_type beat);
         fit_result_type want;
         logic [31:0]    score;
         logic           hit;
         score = fit_score(beat.g_x, beat.g_y, beat.g_z);
         hit = (score < tol_sq) && (score < beat.prior_error);
         want.new_error   = hit ? score : beat.prior_error;
         want.new_label   = hit ? grain_label
                          : (beat.prior_label == grain_label) ? lfsa_pkg::LABEL_NONE
                                                              : beat.prior_label;
         want.assigned    = hit;
         want.last_result = beat.last_vector;
         expected_fits.push_back(want);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_result(fit_result_type got);
         fit_result_type want;
         if (expected_fits.size() == 0) begin
            report_mismatch("result beat with nothing pending");
            return;
         end
         want = expected_fits.pop_front();
         if (got.new_error !== want.new_error)
            report_mismatch($sformatf("new_error %h, want %h", got.new_error, want.new_error));
         if (got.new_label !== want.new_label)
            report_mismatch($sformatf("new_label %h, want %h", got.new_label, want.new_label));
         if (got.assigned !== want.assigned)
            report_mismatch($sformatf("assigned %b, want %b", got.assigned, want.assigned));
         if (got.last_result !== want.last_result)
            report_mismatch($sformatf("last_result %b, want %b", got.last_result,
                                      want.last_result));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [lfsa_pkg::CsrAddrW-1:0] paddr;
   logic [lfsa_pkg::CsrDataW-1:0] pwdata;
   logic [lfsa_pkg::CsrDataW-1:0] prdata;
   logic                          pready;
   bit                            hold_request;
   fit_scoreboard                 sb = new();

   lfsa_req_if req ();
   lfsa_rsp_if rsp ();

   lattice_fit_score_assign dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            sb.note_vector({req.g_x, req.g_y, req.g_z, req.prior_error, req.prior_label,
                            req.last_vector});
         if (rsp.valid && rsp.ready)
            sb.check_result({rsp.new_error, rsp.new_label, rsp.assigned, rsp.last_result});
      end
   end

   // receiver: runs of differing stall density, plus one long hold on request
   initial begin
      int stall_mode;
      int run_len;
      rsp.ready = 1'b0;
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp.ready = 1'b0;
            for (int held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            stall_mode = $urandom_range(0, 3);
            run_len    = $urandom_range(8, 60);
            for (int k = 0; k < run_len && !hold_request; k++) begin
               @(negedge clock);
               case (stall_mode)
                  0: rsp.ready = 1'b1;
                  1: rsp.ready = 1'($urandom_range(0, 1));
                  2: rsp.ready = ($urandom_range(0, 7) != 0);
                  default: rsp.ready = ($urandom_range(0, 4) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

   task automatic write_reg(int idx, logic [63:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = lfsa_pkg::CsrAddrW'(idx * REG_STRIDE);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic send_vector(vector_beat_type beat);
      @(negedge clock);
      req.valid       = 1'b1;
      req.g_x         = beat.g_x;
      req.g_y         = beat.g_y;
      req.g_z         = beat.g_z;
      req.prior_error = beat.prior_error;
      req.prior_label = beat.prior_label;
      req.last_vector = beat.last_vector;
      do @(posedge clock); while (!req.ready);
   endtask

   // drop valid and toggle the idle payload
   task automatic sender_idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req.valid       = 1'b0;
         req.g_x         = $urandom();
         req.prior_label = $urandom();
      end
   endtask

   task automatic wait_drained();
      sender_idle(1);
      while (sb.expected_fits.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   function automatic vector_beat_type make_beat(logic [31:0] gx, logic [31:0] gy,
                                                 logic [31:0] gz, logic [31:0] err,
                                                 logic [31:0] label, logic last);
      vector_beat_type beat;
      beat = {gx, gy, gz, err, label, last};
      return beat;
   endfunction

   // mostly vectors near lattice points so the misfit lands around the tolerance
   function automatic vector_beat_type make_random_vector();
      vector_beat_type beat;
      int              comp [3];
      int              span;
      logic [31:0]     score;
      case ($urandom_range(0, 9))
         0, 1: for (int i = 0; i < 3; i++) comp[i] = $urandom();
         8: for (int i = 0; i < 3; i++) comp[i] = (int'($urandom_range(0, 30)) - 15) * G_HALF;
         9: for (int i = 0; i < 3; i++) comp[i] = EXTREME_G[$urandom_range(0, 3)];
         default: begin
            for (int i = 0; i < 3; i++) begin
               span    = $urandom_range(0, 27);
               comp[i] = (int'($urandom_range(0, 14)) - 7) * G_ONE
                       + int'($urandom_range(0, 2 << span)) - (1 << span);
            end
         end
      endcase
      beat.g_x = comp[0];
      beat.g_y = comp[1];
      beat.g_z = comp[2];
      score = sb.fit_score(comp[0], comp[1], comp[2]);
      case ($urandom_range(0, 7))
         0: beat.prior_error = score;
         1: beat.prior_error = score + 1;
         2: beat.prior_error = score - 1;
         3: beat.prior_error = '0;
         4: beat.prior_error = '1;
         5: beat.prior_error = sb.tol_sq;
         6: beat.prior_error = sb.tol_sq + 1;
         default: beat.prior_error = $urandom();
      endcase
      case ($urandom_range(0, 5))
         0, 1: beat.prior_label = sb.grain_label;
         2: beat.prior_label = lfsa_pkg::LABEL_NONE;
         3: beat.prior_label = {1'b0, 31'($urandom())};
         4: beat.prior_label = $urandom();
         default: beat.prior_label = sb.grain_label | 32'h8000_0000;
      endcase
      beat.last_vector = ($urandom_range(0, 15) == 0);
      return beat;
   endfunction

   task automatic program_random(int style);
      int              m [3][3];
      vector_beat_type probe;
      logic [31:0]     tol;
      foreach (m[r, c]) begin
         case (style)
            0: m[r][c] = $urandom();
            1: m[r][c] = ((r == c) ? int'($urandom_range(1, 3)) * M_ONE
                                     * ($urandom_range(0, 1) ? 1 : -1) : 0)
                         + int'($urandom_range(0, 2048)) - 1024;
            2: m[r][c] = int'($urandom_range(0, 2 << 20)) - (1 << 20);
            default: m[r][c] = EXTREME_COEF[$urandom_range(0, 3)];
         endcase
      end
      write_reg(lfsa_pkg::CSR_M00_M01, {m[0][0], m[0][1]});
      write_reg(lfsa_pkg::CSR_M02_M10, {m[0][2], m[1][0]});
      write_reg(lfsa_pkg::CSR_M11_M12, {m[1][1], m[1][2]});
      write_reg(lfsa_pkg::CSR_M20_M21, {m[2][0], m[2][1]});
      write_reg(lfsa_pkg::CSR_M22, {32'($urandom()), m[2][2]});
      // center the tolerance on a typical vector's score half of the time
      probe = make_random_vector();
      case ($urandom_range(0, 5))
         0, 1: tol = sb.fit_score(probe.g_x, probe.g_y, probe.g_z);
         2: tol = $urandom();
         3: tol = '1;
         4: tol = '0;
         default: tol = sb.fit_score(probe.g_x, probe.g_y, probe.g_z) + $urandom_range(0, 4096);
      endcase
      write_reg(lfsa_pkg::CSR_TOL_SQ, {32'($urandom()), tol});
      write_reg(lfsa_pkg::CSR_LABEL, {32'($urandom()), 32'($urandom())});
   endtask

   task automatic run_phase(int style, int beats, bit squeeze, bit pause);
      int  sent;
      int  burst;
      bit  paused;
      program_random(style);
      sent   = 0;
      paused = 1'b0;
      if (squeeze) begin
         // hold rsp off while streaming so the pipe fills and backs up req
         hold_request = 1'b1;
         repeat (SQUEEZE_BEATS) send_vector(make_random_vector());
         sent += SQUEEZE_BEATS;
      end
      while (sent < beats) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < beats; k++) begin
            send_vector(make_random_vector());
            sent++;
         end
         if (pause && !paused && sent >= beats / 2) begin
            sender_idle(1);
            while (sb.expected_fits.size() != 0) @(posedge clock);
            paused = 1'b1;
         end else if ($urandom_range(0, 3) != 0) begin
            sender_idle($urandom_range(1, 10));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      hold_request    = 1'b0;
      req.valid       = 1'b0;
      req.g_x         = '0;
      req.g_y         = '0;
      req.g_z         = '0;
      req.prior_error = '0;
      req.prior_label = '0;
      req.last_vector = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: zero matrix and zero tolerance, so nothing fits
      send_vector(make_beat('0, '0, '0, '1, '0, 1'b0));
      send_vector(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0,
                            lfsa_pkg::LABEL_NONE, 1'b1));
      send_vector(make_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF,
                            1'b0));
      wait_drained();

      // identity matrix, tolerance 0.25, label 5
      write_reg(lfsa_pkg::CSR_M00_M01, {32'(M_ONE), 32'd0});
      write_reg(lfsa_pkg::CSR_M02_M10, 64'd0);
      write_reg(lfsa_pkg::CSR_M11_M12, {32'(M_ONE), 32'd0});
      write_reg(lfsa_pkg::CSR_M20_M21, 64'd0);
      write_reg(lfsa_pkg::CSR_M22, 64'(M_ONE));
      write_reg(lfsa_pkg::CSR_TOL_SQ, 64'h1000_0000);
      write_reg(lfsa_pkg::CSR_LABEL, 64'd5);
      send_vector(make_beat(G_ONE, -2 * G_ONE, 3 * G_ONE, '1, lfsa_pkg::LABEL_NONE, 1'b0));
      // zero misfit against a zero prior error is still no improvement
      send_vector(make_beat(G_ONE, -2 * G_ONE, 3 * G_ONE, '0, 32'd5, 1'b0));
      // exact halves on every component give the largest misfit
      send_vector(make_beat(G_HALF, G_HALF, G_HALF, '1, 32'd7, 1'b0));
      // one half component lands exactly on the tolerance
      send_vector(make_beat(G_HALF, '0, '0, '1, 32'd5, 1'b0));
      send_vector(make_beat(-G_HALF, G_ONE, '0, '1, 32'd6, 1'b0));
      send_vector(make_beat(G_ONE + 1, '0, '0, 32'd1, 32'h8000_0005, 1'b0));
      send_vector(make_beat('0, '0, '0, '1, '0, 1'b1));
      wait_drained();

      // extreme matrix, full tolerance, label write with the top bit set
      write_reg(lfsa_pkg::CSR_M00_M01, {32'h7FFF_FFFF, 32'h8000_0000});
      write_reg(lfsa_pkg::CSR_M02_M10, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_reg(lfsa_pkg::CSR_M11_M12, {32'h8000_0000, 32'h8000_0000});
      write_reg(lfsa_pkg::CSR_M20_M21, {32'h8000_0000, 32'h7FFF_FFFF});
      write_reg(lfsa_pkg::CSR_M22, {32'hFFFF_FFFF, 32'h7FFF_FFFF});
      write_reg(lfsa_pkg::CSR_TOL_SQ, {32'h0, 32'hFFFF_FFFF});
      write_reg(lfsa_pkg::CSR_LABEL, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(UNUSED_INDEX, 64'h0123_4567_89AB_CDEF);
      send_vector(make_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 32'h7FFF_FFFF,
                            1'b0));
      send_vector(make_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0,
                            lfsa_pkg::LABEL_NONE, 1'b0));
      send_vector(make_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                            lfsa_pkg::LABEL_NONE, 1'b1));
      send_vector(make_beat(32'h0000_0001, '0, 32'hFFFF_FFFF, '0, 32'h7FFF_FFFF, 1'b0));
      send_vector(make_beat('0, 32'h8000_0000, '0, '1, 32'hFFFF_FFFE, 1'b1));
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++)
         run_phase(phase % 4, PHASE_BEATS, phase == 1, phase == 3);

      wait_drained();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* lattice_fit_score_assign.f */
hw/rtl/lfsa_pkg.sv
hw/rtl/lfsa_req_if.sv
hw/rtl/lfsa_rsp_if.sv
hw/rtl/lattice_fit_score_assign.sv
bench/tb_top.sv
